/* sv/crc16_frame_receiver_top_assert.svh */
// Assertion macros for the CRC-16 frame receiver.
`ifndef CRC16_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CRC16_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CRCFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crcfr assertion failed");
`define CRCFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("crcfr assertion failed");
`else
`define CRCFR_ASSERT(lbl, prop)
`define CRCFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* sv/crcfr_pkg.sv */
// Types, constants and the byte-wise CRC-16 update for the frame receiver.
package crcfr_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [7:0]  TAIL_BYTE   = 8'hFF;
  localparam logic [15:0] CRC_POLY    = 16'h8005;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam int          OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_BAD_TAIL = 2'd2
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload;
    logic [7:0] command;
    logic [7:0] frame_length;
    status_t    status;
  } result_t;

  // MSB-first CRC-16, poly 0x8005, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/crcfr_parser.sv */
// Frame parser: sync hunt, header capture, running CRC and end-of-frame check.
module crcfr_parser
  import crcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] byte_in,
  output result_t    result
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC2, PH_LEN, PH_CMD, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO, PH_TAIL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [15:0] crc_upd;
  logic [7:0]  left_dec;

  assign crc_upd  = crc_feed((phase_r == PH_HUNT) ? CRC_INIT : crc_r, byte_in);
  assign left_dec = left_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    length_nxt  = length_r;
    left_nxt    = left_r;
    command_nxt = command_r;
    crc_nxt     = crc_r;
    crc_hi_nxt  = crc_hi_r;
    result      = '{valid: 1'b0, kind: KIND_PAYLOAD, payload: 8'h00,
                    command: command_r, frame_length: length_r, status: ST_GOOD};
    unique case (phase_r)
      PH_HUNT: begin
        if (byte_in == SYNC_FIRST) begin
          crc_nxt   = crc_upd;
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (byte_in == SYNC_SECOND) begin
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEN: begin
        crc_nxt    = crc_upd;
        length_nxt = byte_in;
        phase_nxt  = PH_CMD;
      end
      PH_CMD: begin
        crc_nxt     = crc_upd;
        command_nxt = byte_in;
        left_nxt    = length_r;
        phase_nxt   = (length_r == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_nxt        = crc_upd;
        left_nxt       = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = PH_CRC_HI;
        end
        result.valid   = 1'b1;
        result.payload = byte_in;
      end
      PH_CRC_HI: begin
        crc_hi_nxt = byte_in;
        phase_nxt  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({crc_hi_r, byte_in} == crc_r) begin
          phase_nxt = PH_TAIL;
        end else begin
          phase_nxt     = PH_HUNT;
          result.valid  = 1'b1;
          result.kind   = KIND_REPORT;
          result.status = ST_CRC_ERR;
        end
      end
      PH_TAIL: begin
        phase_nxt     = PH_HUNT;
        result.valid  = 1'b1;
        result.kind   = KIND_REPORT;
        result.status = (byte_in == TAIL_BYTE) ? ST_GOOD : ST_BAD_TAIL;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      length_r  <= 8'h00;
      left_r    <= 8'h00;
      command_r <= 8'h00;
      crc_r     <= CRC_INIT;
      crc_hi_r  <= 8'h00;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      length_r  <= length_nxt;
      left_r    <= left_nxt;
      command_r <= command_nxt;
      crc_r     <= crc_nxt;
      crc_hi_r  <= crc_hi_nxt;
    end
  end

endmodule

/* sv/crc16_frame_receiver_top.sv */
// Framed-packet receiver: A5 5A length command payload crc_hi crc_lo FF, CRC-16/CMS check.
// Takes one received byte per clock cycle while the output side is not stalled. An input
// transaction is registered, and once the output side can accept, the parser and its byte-wise
// CRC-16 update (eight polynomial steps unrolled into combinational logic) load the output
// register, so a result is offered from the output register behind the input register.
// Payload bytes come out as they arrive (tuser 0); the end of each frame gives one report
// (tuser 1) with status good, CRC mismatch (at the low CRC byte) or bad tail byte.
// Bytes outside a frame produce nothing. Stalls on the output side back up into the input.
`include "crc16_frame_receiver_top_assert.svh"

module crc16_frame_receiver_top
  import crcfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [15:8] command,
                                             // [23:16] frame_length, [25:24] status
  output logic [0:0]             out_tuser   // [0] kind
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       stage_go;
  logic       step_en;
  result_t    res;
  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [0:0] out_kind_r;

  assign stage_go  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || stage_go;
  assign step_en   = in_valid_r && stage_go;

  crcfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .byte_in (in_byte_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (stage_go) begin
        out_valid_r <= step_en && res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (stage_go) begin
      out_data_r <= {6'd0, res.status, res.frame_length, res.command, res.payload};
      out_kind_r <= res.kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  `CRCFR_ASSERT(a_in_held, in_valid_r && !stage_go |=> in_valid_r && $stable(in_byte_r))
  `CRCFR_ASSERT(a_payload_status, out_tvalid && out_tuser == 1'b0 |-> out_tdata[25:24] == 2'd0)
  `CRCFR_ASSERT(a_report_no_byte, out_tvalid && out_tuser == 1'b1 |-> out_tdata[7:0] == 8'h00)
  `CRCFR_ASSERT(a_status_code, out_tvalid |-> out_tdata[25:24] != 2'd3)
  `CRCFR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid && !in_valid_r)

endmodule
